@@ src/fcr_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants for the FIFO replacement cache unit.
// No dependencies; imported by the top level and the checker.
package fcr_pkg;

    localparam int unsigned MAX_ENTRIES_DEF  = 1024;
    localparam int unsigned ADDRESS_BITS_DEF = 20;

    localparam int unsigned CFG_BITS  = 11;
    localparam logic [CFG_BITS-1:0] CAP_RESET = 11'd1024;

    localparam int unsigned STAT_BITS = 32;
    localparam int unsigned SUM_BITS  = 64;

    // The presence bitmap is stored as rows of 64 bits.
    localparam int unsigned PRES_SEL_BITS = 6;
    localparam int unsigned PRES_ROW_BITS = 1 << PRES_SEL_BITS;

    // Output word layout, from the lowest bit up, after the miss and evicted flags.
    localparam int unsigned FLAG_BITS = 2;
    localparam int unsigned OUT_FIXED_BITS = FLAG_BITS + 5 * STAT_BITS + 2 * SUM_BITS;

endpackage

@@ src/fcr_ram.sv @@
`timescale 1ns / 1ps
// Simple dual-port synchronous RAM: one write port, one read port, registered read.
// No dependencies; used for the presence bitmap and the replacement ring.
module fcr_ram #(
    parameter int unsigned WIDTH = 64,
    parameter int unsigned DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/fifo_cache_replacement_sim_unit.sv @@
`timescale 1ns / 1ps
// Top level of the FIFO replacement cache simulator.
// Depends on fcr_pkg and fcr_ram (presence bitmap and replacement ring).
//
// Each input word carries one block address; each produces exactly one output word with
// the hit/miss verdict, eviction details and the running statistics. A miss that evicts
// takes longer than a hit or a miss that finds the cache not full, as set by the presence
// bitmap memory: every access reads the row of its address and a miss writes it back, and
// an eviction adds a read-modify-write of the evictee's row followed by a step that adds
// the squared age. The block handles one access at a time and accepts the next input word
// while the previous result still waits in the output register. After reset the bitmap
// is cleared one 64-bit row per cycle across its 2**(ADDRESS_BITS-6) rows (16384 at the
// default width); no input is accepted meanwhile, but capacity writes are taken at any
// time. Capacity is meant to be changed only while idle and followed by a reset; zero
// acts as one and values above MAX_ENTRIES saturate. All counters and sums saturate at
// their all-ones value.
module fifo_cache_replacement_sim_unit
    import fcr_pkg::*;
#(
    parameter int unsigned MAX_ENTRIES  = MAX_ENTRIES_DEF,
    parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF,
    parameter int unsigned IN_W  = ((ADDRESS_BITS + 7) / 8) * 8,
    parameter int unsigned OUT_W = ((OUT_FIXED_BITS + ADDRESS_BITS + 7) / 8) * 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // Capacity register.
    input  logic                i_cfg_wr_en,
    input  logic [CFG_BITS-1:0] i_cfg_wr_data,
    // Input words.
    input  logic                i_s_axis_tvalid,
    output logic                o_s_axis_tready,
    input  logic [IN_W-1:0]     i_s_axis_tdata,   // block_address
    // Output words.
    output logic                o_m_axis_tvalid,
    input  logic                i_m_axis_tready,
    // miss, evicted, evicted_address, evicted_age, access_count, miss_count,
    // fill_point, evict_count, age_sum, age_square_sum
    output logic [OUT_W-1:0]    o_m_axis_tdata
);

    localparam int unsigned OW = $clog2(MAX_ENTRIES);
    localparam int unsigned FW = $clog2(MAX_ENTRIES + 1);
    localparam int unsigned SW = FW + 1;
    localparam int unsigned RW = ADDRESS_BITS - PRES_SEL_BITS;
    localparam int unsigned ROWS = 1 << RW;
    localparam int unsigned EW = STAT_BITS + ADDRESS_BITS;
    localparam int unsigned OUT_BITS = OUT_FIXED_BITS + ADDRESS_BITS;

    typedef enum logic [5:0] {
        S_CLR  = 6'b000001,
        S_IDLE = 6'b000010,
        S_DEC  = 6'b000100,
        S_EVW  = 6'b001000,
        S_SQA  = 6'b010000,
        S_HOLD = 6'b100000
    } t_state;

    function automatic logic [STAT_BITS-1:0] sat_inc(input logic [STAT_BITS-1:0] v);
        sat_inc = (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [SUM_BITS-1:0] sat_trim(input logic [SUM_BITS:0] v);
        sat_trim = v[SUM_BITS] ? '1 : v[SUM_BITS-1:0];
    endfunction

    // Control state.
    t_state                r_state, n_state;
    logic [RW-1:0]         r_clr, n_clr;
    logic [CFG_BITS-1:0]   r_cap;
    logic [OW-1:0]         r_oldest, n_oldest;
    logic [FW-1:0]         r_fill, n_fill;
    logic [STAT_BITS-1:0]  r_acc, n_acc;
    logic [STAT_BITS-1:0]  r_missc, n_missc;
    logic [STAT_BITS-1:0]  r_fillm, n_fillm;
    logic [STAT_BITS-1:0]  r_evc, n_evc;
    logic [SUM_BITS-1:0]   r_sum, n_sum;
    logic [SUM_BITS-1:0]   r_sqsum, n_sqsum;
    logic                  r_ovalid;

    // Per-access payload.
    logic [ADDRESS_BITS-1:0]  r_addr, n_addr;
    logic                     r_miss, n_miss;
    logic                     r_evict, n_evict;
    logic [ADDRESS_BITS-1:0]  r_evaddr, n_evaddr;
    logic [STAT_BITS-1:0]     r_age, n_age;
    logic [SUM_BITS-1:0]      r_sq, n_sq;
    logic                     r_fwd, n_fwd;
    logic [PRES_ROW_BITS-1:0] r_wrow, n_wrow;
    logic [OUT_W-1:0]         r_odata;

    // Memory ports.
    logic                     pres_we, pres_re;
    logic [RW-1:0]            pres_waddr, pres_raddr;
    logic [PRES_ROW_BITS-1:0] pres_wdata, pres_rdata;
    logic                     ring_we, ring_re;
    logic [OW-1:0]            ring_waddr, ring_raddr;
    logic [EW-1:0]            ring_wdata, ring_rdata;

    // Datapath helpers.
    logic                     w_in_acc;
    logic                     w_out_free;
    logic                     w_emit;
    logic [ADDRESS_BITS-1:0]  w_in_addr;
    logic [31:0]              w_cap;
    logic                     w_not_full;
    logic                     w_hit;
    logic [ADDRESS_BITS-1:0]  w_ring_addr;
    logic [STAT_BITS-1:0]     w_ring_stamp;
    logic [SW-1:0]            w_slot_sum;
    logic [OW-1:0]            w_slot;
    logic [OW-1:0]            w_oldest_inc;
    logic [PRES_ROW_BITS-1:0] w_row_set;
    logic [PRES_ROW_BITS-1:0] w_row_clr;
    logic [SUM_BITS-1:0]      w_sq;
    logic [SUM_BITS:0]        w_sum_ext;
    logic [SUM_BITS:0]        w_sqsum_ext;
    logic [OUT_W-1:0]         w_pack;

    fcr_ram #(
        .WIDTH (PRES_ROW_BITS),
        .DEPTH (ROWS)
    ) u_presence (
        .i_clk   (i_clk),
        .i_we    (pres_we),
        .i_waddr (pres_waddr),
        .i_wdata (pres_wdata),
        .i_re    (pres_re),
        .i_raddr (pres_raddr),
        .o_rdata (pres_rdata)
    );

    // Ring entries hold {insertion stamp, block address}.
    fcr_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (ring_waddr),
        .i_wdata (ring_wdata),
        .i_re    (ring_re),
        .i_raddr (ring_raddr),
        .o_rdata (ring_rdata)
    );

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_out_free = !r_ovalid || i_m_axis_tready;
    assign w_in_addr  = i_s_axis_tdata[ADDRESS_BITS-1:0];

    // Effective capacity: zero acts as one, values above the ring size saturate.
    always_comb begin
        w_cap = 32'(r_cap);
        if (w_cap == 32'd0) begin
            w_cap = 32'd1;
        end
        if (w_cap > 32'(MAX_ENTRIES)) begin
            w_cap = 32'(MAX_ENTRIES);
        end
    end

    assign w_not_full   = 32'(r_fill) < w_cap;
    assign w_hit        = pres_rdata[r_addr[PRES_SEL_BITS-1:0]];
    assign w_ring_addr  = ring_rdata[ADDRESS_BITS-1:0];
    assign w_ring_stamp = ring_rdata[EW-1:ADDRESS_BITS];

    // The new entry always lands at oldest + fill_level (mod ring size), taken before
    // either pointer moves; the sum stays below twice the ring size.
    assign w_slot_sum = SW'(r_oldest) + SW'(r_fill);
    assign w_slot = (w_slot_sum >= SW'(MAX_ENTRIES)) ? OW'(w_slot_sum - SW'(MAX_ENTRIES))
                                                     : OW'(w_slot_sum);
    assign w_oldest_inc = (r_oldest == OW'(MAX_ENTRIES - 1)) ? '0 : r_oldest + 1'b1;

    assign w_row_set = pres_rdata
                     | (PRES_ROW_BITS'(1) << r_addr[PRES_SEL_BITS-1:0]);
    // When the evictee shares a row with the address just inserted, the read taken in the
    // same cycle as that write returned stale data, so the written row is used instead.
    assign w_row_clr = (r_fwd ? r_wrow : pres_rdata)
                     & ~(PRES_ROW_BITS'(1) << r_evaddr[PRES_SEL_BITS-1:0]);

    assign w_sq        = r_age * r_age;
    assign w_sum_ext   = {1'b0, r_sum} + (SUM_BITS + 1)'(r_age);
    assign w_sqsum_ext = {1'b0, r_sqsum} + {1'b0, r_sq};

    always_comb begin
        n_state  = r_state;
        n_clr    = r_clr;
        n_oldest = r_oldest;
        n_fill   = r_fill;
        n_acc    = r_acc;
        n_missc  = r_missc;
        n_fillm  = r_fillm;
        n_evc    = r_evc;
        n_sum    = r_sum;
        n_sqsum  = r_sqsum;
        n_addr   = r_addr;
        n_miss   = r_miss;
        n_evict  = r_evict;
        n_evaddr = r_evaddr;
        n_age    = r_age;
        n_sq     = r_sq;
        n_fwd    = r_fwd;
        n_wrow   = r_wrow;
        w_emit   = 1'b0;

        pres_we    = 1'b0;
        pres_waddr = r_addr[ADDRESS_BITS-1:PRES_SEL_BITS];
        pres_wdata = w_row_set;
        pres_re    = 1'b0;
        pres_raddr = w_in_addr[ADDRESS_BITS-1:PRES_SEL_BITS];
        ring_we    = 1'b0;
        ring_waddr = w_slot;
        ring_wdata = {r_acc, r_addr};
        ring_re    = 1'b0;
        ring_raddr = r_oldest;

        unique case (r_state)
            S_CLR: begin
                pres_we    = 1'b1;
                pres_waddr = r_clr;
                pres_wdata = '0;
                n_clr      = r_clr + 1'b1;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_in_acc) begin
                    n_addr  = w_in_addr;
                    n_acc   = sat_inc(r_acc);
                    pres_re = 1'b1;
                    ring_re = 1'b1;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                n_miss   = !w_hit;
                n_evict  = 1'b0;
                n_evaddr = '0;
                n_age    = '0;
                if (!w_hit) begin
                    n_missc = sat_inc(r_missc);
                    pres_we = 1'b1;
                    ring_we = 1'b1;
                    if (w_not_full) begin
                        n_fillm = r_acc;
                        n_fill  = r_fill + 1'b1;
                    end else begin
                        n_evict    = 1'b1;
                        n_evaddr   = w_ring_addr;
                        n_age      = r_acc - w_ring_stamp;
                        n_evc      = sat_inc(r_evc);
                        n_oldest   = w_oldest_inc;
                        pres_re    = 1'b1;
                        pres_raddr = w_ring_addr[ADDRESS_BITS-1:PRES_SEL_BITS];
                        n_fwd      = (w_ring_addr[ADDRESS_BITS-1:PRES_SEL_BITS]
                                      == r_addr[ADDRESS_BITS-1:PRES_SEL_BITS]);
                        n_wrow     = w_row_set;
                    end
                end
                if (w_hit || w_not_full) begin
                    if (w_out_free) begin
                        w_emit  = 1'b1;
                        n_state = S_IDLE;
                    end else begin
                        n_state = S_HOLD;
                    end
                end else begin
                    n_state = S_EVW;
                end
            end
            S_EVW: begin
                pres_we    = 1'b1;
                pres_waddr = r_evaddr[ADDRESS_BITS-1:PRES_SEL_BITS];
                pres_wdata = w_row_clr;
                n_sq       = w_sq;
                n_sum      = sat_trim(w_sum_ext);
                n_state    = S_SQA;
            end
            S_SQA: begin
                n_sqsum = sat_trim(w_sqsum_ext);
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_state = S_HOLD;
                end
            end
            S_HOLD: begin
                if (w_out_free) begin
                    w_emit  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLR;
            end
        endcase
    end

    // Result word, built from the values that this cycle's update leaves behind.
    always_comb begin
        w_pack = '0;
        w_pack[OUT_BITS-1:0] = {n_sqsum, n_sum, n_evc, n_fillm, n_missc, n_acc,
                                n_age, n_evaddr, n_evict, n_miss};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLR;
            r_clr    <= '0;
            r_cap    <= CAP_RESET;
            r_oldest <= '0;
            r_fill   <= '0;
            r_acc    <= '0;
            r_missc  <= '0;
            r_fillm  <= '0;
            r_evc    <= '0;
            r_sum    <= '0;
            r_sqsum  <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_clr    <= n_clr;
            r_oldest <= n_oldest;
            r_fill   <= n_fill;
            r_acc    <= n_acc;
            r_missc  <= n_missc;
            r_fillm  <= n_fillm;
            r_evc    <= n_evc;
            r_sum    <= n_sum;
            r_sqsum  <= n_sqsum;
            if (i_cfg_wr_en) begin
                r_cap <= i_cfg_wr_data;
            end
            if (w_emit) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_miss   <= n_miss;
        r_evict  <= n_evict;
        r_evaddr <= n_evaddr;
        r_age    <= n_age;
        r_sq     <= n_sq;
        r_fwd    <= n_fwd;
        r_wrow   <= n_wrow;
        if (w_emit) begin
            r_odata <= w_pack;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

endmodule

@@ src/fcr_checker.sv @@
`timescale 1ns / 1ps
// Port-level assertions for the FIFO replacement cache unit, bound to the top level.
// Depends on fcr_pkg and fifo_cache_replacement_sim_unit.
module fcr_checker
    import fcr_pkg::*;
#(
    parameter int unsigned ADDRESS_BITS = ADDRESS_BITS_DEF,
    parameter int unsigned OUT_W = ((OUT_FIXED_BITS + ADDRESS_BITS + 7) / 8) * 8
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_s_axis_tvalid,
    input logic             o_s_axis_tready,
    input logic             o_m_axis_tvalid,
    input logic             i_m_axis_tready,
    input logic [OUT_W-1:0] o_m_axis_tdata
);

    localparam int unsigned EVA_LSB = FLAG_BITS;
    localparam int unsigned AGE_LSB = EVA_LSB + ADDRESS_BITS;
    localparam int unsigned ACC_LSB = AGE_LSB + STAT_BITS;
    localparam int unsigned MC_LSB  = ACC_LSB + STAT_BITS;
    localparam int unsigned FP_LSB  = MC_LSB + STAT_BITS;
    localparam int unsigned EC_LSB  = FP_LSB + STAT_BITS;

    logic                    w_miss;
    logic                    w_evicted;
    logic [ADDRESS_BITS-1:0] w_evaddr;
    logic [STAT_BITS-1:0]    w_age;
    logic [STAT_BITS-1:0]    w_acc;
    logic [STAT_BITS-1:0]    w_mc;
    logic [STAT_BITS-1:0]    w_ec;

    assign w_miss    = o_m_axis_tdata[0];
    assign w_evicted = o_m_axis_tdata[1];
    assign w_evaddr  = o_m_axis_tdata[EVA_LSB +: ADDRESS_BITS];
    assign w_age     = o_m_axis_tdata[AGE_LSB +: STAT_BITS];
    assign w_acc     = o_m_axis_tdata[ACC_LSB +: STAT_BITS];
    assign w_mc      = o_m_axis_tdata[MC_LSB +: STAT_BITS];
    assign w_ec      = o_m_axis_tdata[EC_LSB +: STAT_BITS];

    // Accesses are processed one at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> !o_s_axis_tready)
        else $error("input accepted on two consecutive cycles");

    // Only a miss can evict.
    a_evict_needs_miss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && w_evicted) |-> w_miss)
        else $error("eviction reported on a hit");

    // Without an eviction the evictee fields read as zero.
    a_no_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !w_evicted) |-> (w_evaddr == '0 && w_age == '0))
        else $error("evictee fields nonzero without eviction");

    // Evictions never outnumber misses, and misses never outnumber accesses.
    a_count_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (w_ec <= w_mc && w_mc <= w_acc))
        else $error("statistics counters out of order");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && !i_m_axis_tready) |=>
            (o_m_axis_tvalid && $stable(o_m_axis_tdata)))
        else $error("stalled output word changed");

endmodule

bind fifo_cache_replacement_sim_unit fcr_checker #(
    .ADDRESS_BITS (ADDRESS_BITS),
    .OUT_W        (OUT_W)
) u_fcr_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);

@@ dv/fifo_cache_replacement_sim_unit_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the FIFO replacement cache unit: a clocked stream driver and
// monitor, with a built-in cache predictor. Depends on fcr_pkg and the unit's top level.
module fifo_cache_replacement_sim_unit_tb;
    import fcr_pkg::*;

    localparam int unsigned ADDR_BITS = ADDRESS_BITS_DEF;
    localparam int unsigned ENTRIES   = MAX_ENTRIES_DEF;
    localparam int unsigned IN_W      = ((ADDR_BITS + 7) / 8) * 8;
    localparam int unsigned OUT_W     = ((OUT_FIXED_BITS + ADDR_BITS + 7) / 8) * 8;

    // The watchdog has to outlast the bitmap clearing pass after reset plus the longest
    // receiver hold, with a wide margin.
    localparam int unsigned QUIET_LIMIT = 80000;
    localparam int unsigned HOLD_CYCLES = 400;
    localparam int unsigned MAX_REPORTS = 10;

    localparam logic [ADDR_BITS-1:0] ADDR_LOW  = '0;
    localparam logic [ADDR_BITS-1:0] ADDR_HIGH = '1;

    // One output word, declared from the highest field down so that the miss flag lands
    // in bit 0 and the packing matches the unit's tdata layout.
    typedef struct packed {
        logic [SUM_BITS-1:0]  age_square_sum;
        logic [SUM_BITS-1:0]  age_sum;
        logic [STAT_BITS-1:0] evict_count;
        logic [STAT_BITS-1:0] fill_point;
        logic [STAT_BITS-1:0] miss_count;
        logic [STAT_BITS-1:0] access_count;
        logic [STAT_BITS-1:0] evicted_age;
        logic [ADDR_BITS-1:0] evicted_address;
        logic                 evicted;
        logic                 miss;
    } t_access_report;

    localparam int unsigned REPORT_BITS = $bits(t_access_report);

    // The receiver switches between a few pacing styles so that its stalls land on
    // every phase of an access.
    typedef enum logic [1:0] {
        RX_STEADY,
        RX_RANDOM,
        RX_SPARSE
    } t_rx_pace;

    // ------------------------------------------------------------------------
    // Clock, reset and the signals that face the unit. Every input starts at a
    // known value so nothing is X while the unit sits in reset.
    // ------------------------------------------------------------------------
    logic                i_clk           = 1'b0;
    logic                i_rst_n         = 1'b0;
    logic                i_cfg_wr_en     = 1'b0;
    logic [CFG_BITS-1:0] i_cfg_wr_data   = '0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [IN_W-1:0]     i_s_axis_tdata  = '0;   // block_address
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    // miss, evicted, evicted_address, evicted_age, access_count, miss_count,
    // fill_point, evict_count, age_sum, age_square_sum
    logic [OUT_W-1:0]    o_m_axis_tdata;

    always #1 i_clk = ~i_clk;

    fifo_cache_replacement_sim_unit u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Cache predictor. It keeps its own presence map, replacement ring and
    // statistics, and is advanced once for every address the unit accepts.
    // The presence map starts cleared and the run resets the unit only once,
    // so it never needs clearing again.
    // ------------------------------------------------------------------------
    bit                   present_map [0:(1 << ADDR_BITS)-1];
    logic [ADDR_BITS-1:0] slot_address [0:ENTRIES-1];
    logic [STAT_BITS-1:0] slot_stamp [0:ENTRIES-1];
    logic [9:0]           head_slot        = '0;
    int unsigned          occupancy        = 0;
    logic [STAT_BITS-1:0] accesses         = '0;
    logic [STAT_BITS-1:0] misses           = '0;
    logic [STAT_BITS-1:0] last_fill_access = '0;
    logic [STAT_BITS-1:0] evictions        = '0;
    logic [SUM_BITS-1:0]  age_total        = '0;
    logic [SUM_BITS-1:0]  age_sq_total     = '0;
    logic [CFG_BITS-1:0]  capacity_setting = CAP_RESET;

    function automatic logic [STAT_BITS-1:0] sat_inc(input logic [STAT_BITS-1:0] v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                    input logic [SUM_BITS-1:0] b);
        logic [SUM_BITS-1:0] s;
        s = a + b;
        return (s < a) ? '1 : s;
    endfunction

    function automatic t_access_report cache_lookup(input logic [ADDR_BITS-1:0] addr);
        t_access_report      r;
        int unsigned         cap;
        logic [SUM_BITS-1:0] age64;
        logic [9:0]          slot;
        r = '0;
        accesses = sat_inc(accesses);
        if (!present_map[addr]) begin
            // Zero behaves as a capacity of one; anything above the ring size saturates.
            cap = (capacity_setting == 0) ? 1 : int'(capacity_setting);
            if (cap > ENTRIES) begin
                cap = ENTRIES;
            end
            r.miss = 1'b1;
            misses = sat_inc(misses);
            if (occupancy < cap) begin
                last_fill_access = accesses;
                occupancy++;
            end else begin
                // A lowered capacity lands here too: one out, one in, so the
                // occupancy stays where it was.
                r.evicted         = 1'b1;
                r.evicted_address = slot_address[head_slot];
                r.evicted_age     = accesses - slot_stamp[head_slot];
                age64             = {32'b0, r.evicted_age};
                evictions         = sat_inc(evictions);
                age_total         = sat_add(age_total, age64);
                age_sq_total      = sat_add(age_sq_total, age64 * age64);
                present_map[r.evicted_address] = 1'b0;
                head_slot = head_slot + 1'b1;
            end
            slot = 10'((32'(head_slot) + occupancy - 1) % ENTRIES);
            slot_address[slot] = addr;
            slot_stamp[slot]   = accesses;
            present_map[addr]  = 1'b1;
        end
        r.access_count   = accesses;
        r.miss_count     = misses;
        r.fill_point     = last_fill_access;
        r.evict_count    = evictions;
        r.age_sum        = age_total;
        r.age_square_sum = age_sq_total;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Shared bookkeeping between the stimulus, the driver and the monitor.
    // ------------------------------------------------------------------------
    logic [ADDR_BITS-1:0] pending_addresses [$];
    t_access_report       expected_reports [$];
    int unsigned          mismatch_count = 0;
    int unsigned          results_seen   = 0;

    // ------------------------------------------------------------------------
    // Driver. It offers addresses from the pending queue in bursts of random
    // length separated by random gaps; some gaps are zero, which gives long
    // back-to-back stretches. The predictor runs at the edge where a word is
    // accepted, so the expectation queue stays in acceptance order.
    // ------------------------------------------------------------------------
    int unsigned burst_left = 0;
    int unsigned gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                expected_reports.push_back(cache_lookup(i_s_axis_tdata[ADDR_BITS-1:0]));
            end
            // A new word may only be put up once the current one has gone.
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (pending_addresses.size() > 0) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {{(IN_W - ADDR_BITS){1'b0}},
                                        pending_addresses.pop_front()};
                    if (burst_left <= 1) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left--;
                    end
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor. Each accepted output word is split into its fields and compared
    // with the oldest expectation. Ready follows a randomly chosen pacing style,
    // and twice during the run the receiver holds off
    // for a long stretch while the sender keeps offering, so the unit backs up
    // and drops its input ready.
    // ------------------------------------------------------------------------
    t_rx_pace    rx_pace      = RX_STEADY;
    int unsigned pace_left    = 0;
    int unsigned hold_left    = 0;

    task automatic compare_field(input string field, input logic [SUM_BITS-1:0] want,
                                 input logic [SUM_BITS-1:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("Mismatch on output word %0d, field %s: expected 0x%0h, got 0x%0h",
                         results_seen, field, want, got);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_access_report want;
        t_access_report got;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got = t_access_report'(o_m_axis_tdata[REPORT_BITS-1:0]);
                if (expected_reports.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("Unexpected output word %0d with no access pending",
                                 results_seen);
                    end
                end else begin
                    want = expected_reports.pop_front();
                    compare_field("miss", want.miss, got.miss);
                    compare_field("evicted", want.evicted, got.evicted);
                    compare_field("evicted_address", want.evicted_address,
                                  got.evicted_address);
                    compare_field("evicted_age", want.evicted_age, got.evicted_age);
                    compare_field("access_count", want.access_count, got.access_count);
                    compare_field("miss_count", want.miss_count, got.miss_count);
                    compare_field("fill_point", want.fill_point, got.fill_point);
                    compare_field("evict_count", want.evict_count, got.evict_count);
                    compare_field("age_sum", want.age_sum, got.age_sum);
                    compare_field("age_square_sum", want.age_square_sum,
                                  got.age_square_sum);
                end
                results_seen++;
                // Both points fall inside long random phases, so input keeps coming.
                if (results_seen == 100 || results_seen == 350) begin
                    hold_left = HOLD_CYCLES;
                end
            end

            if (hold_left > 0) begin
                hold_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                if (pace_left == 0) begin
                    rx_pace   = t_rx_pace'($urandom_range(0, 2));
                    pace_left = $urandom_range(16, 96);
                end else begin
                    pace_left--;
                end
                case (rx_pace)
                    RX_STEADY: begin
                        i_m_axis_tready <= 1'b1;
                    end
                    RX_RANDOM: begin
                        i_m_axis_tready <= 1'($urandom_range(0, 1));
                    end
                    default: begin
                        i_m_axis_tready <= ($urandom_range(0, 3) == 0);
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: ends the run if no word moves on either side for too long.
    // ------------------------------------------------------------------------
    int unsigned quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready)
                || (o_m_axis_tvalid && i_m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus. Work is loaded into the pending queue phase by phase. Between
    // phases the sender pauses until every expected word has come back, and
    // only then is the capacity register written, so each write lands while
    // the unit is idle. Checks are made at the falling edge, away from the
    // clocked processes.
    // ------------------------------------------------------------------------
    task automatic wait_idle();
        @(negedge i_clk);
        while (pending_addresses.size() != 0 || expected_reports.size() != 0
                || i_s_axis_tvalid) begin
            @(negedge i_clk);
        end
    endtask

    task automatic set_capacity(input logic [CFG_BITS-1:0] value);
        wait_idle();
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        capacity_setting = value;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        @(negedge i_clk);
    endtask

    // Most random words reuse a small hot set of the size the caller gives, which
    // gives a steady mix of hits, refills and evictions. The rest are fresh
    // addresses and the two ends of the address space. A hot set of zero
    // means a stream of nearly all fresh addresses, used to fill the ring.
    task automatic load_random_phase(input int unsigned count, input int unsigned hot_size);
        logic [ADDR_BITS-1:0] hot_set [$];
        int unsigned          roll;
        hot_set.delete();
        repeat (hot_size) begin
            hot_set.push_back(ADDR_BITS'($urandom));
        end
        repeat (count) begin
            roll = $urandom_range(0, 99);
            if (roll < 65 && hot_set.size() > 0) begin
                pending_addresses.push_back(hot_set[$urandom_range(0, hot_set.size() - 1)]);
            end else if (roll < 70) begin
                pending_addresses.push_back(($urandom_range(0, 1) == 0) ? ADDR_LOW
                                                                        : ADDR_HIGH);
            end else begin
                pending_addresses.push_back(ADDR_BITS'($urandom));
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed part at the reset capacity: both ends of the address space,
        // hits on them, alternating bit patterns.
        pending_addresses.push_back(20'h00000);
        pending_addresses.push_back(20'hFFFFF);
        pending_addresses.push_back(20'h00000);
        pending_addresses.push_back(20'hFFFFF);
        pending_addresses.push_back(20'hAAAAA);
        pending_addresses.push_back(20'h55555);
        pending_addresses.push_back(20'h00001);
        pending_addresses.push_back(20'h80000);

        // Capacity zero acts as one. Lowering it with six entries held means
        // each miss evicts the oldest and appends, while older entries still hit.
        set_capacity(11'd0);
        pending_addresses.push_back(20'h12345);
        pending_addresses.push_back(20'hFFFFF);
        pending_addresses.push_back(20'h00000);
        pending_addresses.push_back(20'h12345);
        pending_addresses.push_back(20'hFFFFF);
        pending_addresses.push_back(20'h7FFFF);

        // All ones saturates to the full ring size, so the ring refills.
        set_capacity(11'h7FF);
        pending_addresses.push_back(20'hAAAAA);
        pending_addresses.push_back(20'h00000);
        pending_addresses.push_back(20'h55555);
        pending_addresses.push_back(20'hFFFFF);
        pending_addresses.push_back(20'h0F0F0);

        // Random phases over a range of capacities, small ones first.
        set_capacity(11'd1);
        load_random_phase(40, 3);
        set_capacity(11'd4);
        load_random_phase(60, 6);
        set_capacity(11'd16);
        load_random_phase(70, 24);

        // Mostly fresh misses at a moderate capacity: the ring fills up to it
        // and then keeps evicting.
        set_capacity(11'd32);
        load_random_phase(60, 0);

        // Capacity cut sharply from a full ring, then raised far above the fill.
        set_capacity(11'd3);
        load_random_phase(70, 5);
        set_capacity(11'd1000);
        load_random_phase(50, 12);
        set_capacity(11'd2);
        load_random_phase(60, 4);
        set_capacity(11'd0);
        load_random_phase(30, 2);

        // Drain, then give the unit a few more cycles to show any stray word.
        wait_idle();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
